// File: hdl/pbpo_pkg.sv
package pbpo_pkg;

  localparam int NMAPS   = 4;   // plane-map registers, one per stored block
  localparam int NPIX    = 4;   // bits in a pixel (destination planes)
  localparam int PLANES  = 4;   // longest destination list
  localparam int MAP_W   = 8;
  localparam int NIB_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int CNT_W   = 5;   // holds an entry count up to NMAPS * NPIX

  localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;

  typedef enum logic [1:0] {
    KIND_COPY = 2'd0,
    KIND_AND  = 2'd1,
    KIND_OR   = 2'd2,
    KIND_XOR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MAP0 = 2'd0,
    REG_MAP1 = 2'd1,
    REG_MAP2 = 2'd2,
    REG_MAP3 = 2'd3
  } reg_idx_t;

  // Per-plane summary of the destination list for one transaction.
  typedef struct packed {
    logic [NPIX-1:0] has;    // plane has at least one entry
    logic [NPIX-1:0] cpy;    // sprite bit of the earliest entry
    logic [NPIX-1:0] andc;   // some entry carries a zero sprite bit
    logic [NPIX-1:0] orset;  // some entry carries a one sprite bit
    logic [NPIX-1:0] xorp;   // parity of entries carrying a one
  } plane_sum_t;

endpackage

// File: hdl/planar_blitter_pixel_op.sv
// The start is registered through valid1 and valid2 into the done strobe carrying the result.
// Throughput: one transaction per cycle; busy is always low and every stage
// advances each cycle, since the receiver cannot stall the done strobe.
// Reset (rst, synchronous, active high) clears the four plane maps to zero
// and drops every transaction in flight; payload registers are not reset.
module planar_blitter_pixel_op (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [3:0]                    sprite_bits,
  input  logic [3:0]                    dest_pixel,
  output logic                          done,
  output logic [3:0]                    new_pixel,
  output logic                          can_change,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbpo_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbpo_pkg::DATA_W-1:0]   pwdata,
  output logic [pbpo_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import pbpo_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration: four plane maps at byte addresses 0, 4, 8, 12.
  // ---------------------------------------------------------------------
  logic [NMAPS-1:0][MAP_W-1:0] plane_map;
  reg_idx_t                    reg_sel;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(DATA_W-MAP_W){1'b0}}, plane_map[reg_sel]};

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_map <= '0;
    end else if (cfg_wr) begin
      plane_map[reg_sel] <= pwdata[MAP_W-1:0];
    end
  end

  // Never hold off a transaction: the pipeline moves every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Destination list decode. en[p][b] marks an entry that feeds plane b
  // from stored block p. Scan the maps in order, stop at the first empty
  // low nibble, and drop entries once the list holds PLANES of them.
  // ---------------------------------------------------------------------
  logic [NMAPS-1:0][NPIX-1:0] en1_next;

  always_comb begin
    logic             active;
    logic [CNT_W-1:0] cnt;
    active   = 1'b1;
    cnt      = '0;
    en1_next = '0;
    for (int p = 0; p < NMAPS; p++) begin
      if ((plane_map[p][NIB_W-1:0] & NIB_MASK) == '0) begin
        active = 1'b0;
      end
      for (int b = 0; b < NPIX; b++) begin
        if (active && plane_map[p][b] && (cnt < CNT_W'(PLANES))) begin
          en1_next[p][b] = 1'b1;
          cnt            = cnt + CNT_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the transaction with a snapshot of the decoded list
  // and masks, so all later stages see one consistent configuration.
  // ---------------------------------------------------------------------
  logic                       valid1;
  kind_t                      kind1;
  logic [NMAPS-1:0]           spr1;
  logic [NPIX-1:0]            dst1;
  logic [NMAPS-1:0][NPIX-1:0] en1;
  logic [NPIX-1:0]            clr1;
  logic [NPIX-1:0]            set1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    kind1 <= kind_t'(kind);
    spr1  <= sprite_bits;
    dst1  <= dest_pixel;
    en1   <= en1_next;
    clr1  <= plane_map[REG_MAP0][MAP_W-1:NIB_W];
    set1  <= plane_map[REG_MAP1][MAP_W-1:NIB_W];
  end

  // ---------------------------------------------------------------------
  // Stage 2: fold the list per destination plane. The earliest entry wins
  // for copy; and/or look for any matching entry; xor takes the parity.
  // ---------------------------------------------------------------------
  plane_sum_t sum2_next;

  always_comb begin
    sum2_next = '0;
    for (int b = 0; b < NPIX; b++) begin
      for (int p = NMAPS - 1; p >= 0; p--) begin
        if (en1[p][b]) begin
          sum2_next.has[b]   = 1'b1;
          sum2_next.cpy[b]   = spr1[p];
          sum2_next.andc[b]  = sum2_next.andc[b] | ~spr1[p];
          sum2_next.orset[b] = sum2_next.orset[b] | spr1[p];
          sum2_next.xorp[b]  = sum2_next.xorp[b] ^ spr1[p];
        end
      end
    end
  end

  logic            valid2;
  kind_t           kind2;
  logic [NPIX-1:0] dst2;
  logic [NPIX-1:0] clr2;
  logic [NPIX-1:0] set2;
  plane_sum_t      sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    kind2 <= kind1;
    dst2  <= dst1;
    clr2  <= clr1;
    set2  <= set1;
    sum2  <= sum2_next;
  end

  // ---------------------------------------------------------------------
  // Stage 3: apply the operation. Each plane is an independent one-bit
  // function of the destination bit, so the pixel can change for some
  // destination value exactly when some plane function is not identity.
  // ---------------------------------------------------------------------
  logic [NPIX-1:0] pix3_next;
  logic            chg3_next;

  always_comb begin
    case (kind2)
      KIND_COPY: begin
        pix3_next = (sum2.has & sum2.cpy) | (~sum2.has & ((dst2 & ~clr2) | set2));
        chg3_next = |(sum2.has | clr2 | set2);
      end
      KIND_AND: begin
        pix3_next = dst2 & ~clr2 & ~sum2.andc;
        chg3_next = |(clr2 | sum2.andc);
      end
      KIND_OR: begin
        pix3_next = dst2 | set2 | sum2.orset;
        chg3_next = |(set2 | sum2.orset);
      end
      KIND_XOR: begin
        pix3_next = dst2 ^ set2 ^ sum2.xorp;
        chg3_next = |(set2 ^ sum2.xorp);
      end
      default: begin
        pix3_next = dst2;
        chg3_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    new_pixel  <= pix3_next;
    can_change <= chg3_next;
  end

`ifndef SYNTHESIS
  // A strobe only ever follows a start that passed through valid1 and valid2.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("done without a matching start");

  // A sprite value that cannot change anything leaves the pixel as it was.
  a_no_change_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && !can_change) |-> (new_pixel == $past(dest_pixel, 3)))
    else $error("pixel changed although can_change is low");

  // The decoded destination list never exceeds its capacity.
  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    valid1 |-> ($countones(en1) <= PLANES))
    else $error("destination list too long");

  // A copy through any list entry always counts as a possible change.
  a_copy_entry_changes: assert property (@(posedge clk) disable iff (rst)
    (valid2 && (kind2 == KIND_COPY) && (sum2.has != '0)) |=> can_change)
    else $error("copy with entries flagged as no change");
`endif

endmodule

// File: bench/tb_planar_blitter_pixel_op.sv
module tb_planar_blitter_pixel_op;
  timeunit 1ns;
  timeprecision 1ps;

  import pbpo_pkg::*;

  // Three-stage pipeline; add slack for the final quiet window.
  localparam int LATENCY     = 3;
  localparam int STALL_LIMIT = 1000;
  localparam int PRINT_LIMIT = 50;

  // One expected transaction on the result side.
  typedef struct packed {
    logic [NPIX-1:0] pix;
    logic            chg;
  } pixel_result_t;

  // Scoreboard: mirrors the four plane maps, predicts each accepted pixel and
  // compares the done strobes against the oldest pending prediction.
  class pixel_op_scoreboard;
    logic [MAP_W-1:0] maps [NMAPS];
    pixel_result_t    pending_q [$];
    int               mismatches;

    function new();
      for (int i = 0; i < NMAPS; i++) maps[i] = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Apply one raster op to a destination pixel under the current maps.
    function logic [NPIX-1:0] blit(kind_t k, logic [NPIX-1:0] spr, logic [NPIX-1:0] dst);
      int               pln [PLANES];
      int               blk [PLANES];
      int               n;
      logic             stop;
      logic [NIB_W-1:0] nib;
      logic [NIB_W-1:0] clr_mask;
      logic [NIB_W-1:0] set_mask;
      logic [NPIX-1:0]  x;
      n = 0;
      stop = 1'b0;
      clr_mask = maps[REG_MAP0][MAP_W-1:NIB_W];
      set_mask = maps[REG_MAP1][MAP_W-1:NIB_W];
      x = dst;
      for (int i = 0; i < PLANES; i++) begin
        pln[i] = 0;
        blk[i] = 0;
      end
      // Build the destination list; an empty low nibble ends the scan.
      for (int p = 0; p < NMAPS; p++) begin
        nib = maps[p][NIB_W-1:0];
        if (nib == '0) stop = 1'b1;
        if (!stop) begin
          for (int b = 0; b < NPIX; b++) begin
            if (nib[b] && n < PLANES) begin
              pln[n] = b;
              blk[n] = p;
              n++;
            end
          end
        end
      end
      case (k)
        KIND_COPY: begin
          x = (x & ~clr_mask) | set_mask;
          // Walk backward so the earliest entry for a plane lands last.
          for (int e = n - 1; e >= 0; e--) x[pln[e]] = spr[blk[e]];
        end
        KIND_AND: begin
          x = x & ~clr_mask;
          for (int e = 0; e < n; e++) if (!spr[blk[e]]) x[pln[e]] = 1'b0;
        end
        KIND_OR: begin
          x = x | set_mask;
          for (int e = 0; e < n; e++) if (spr[blk[e]]) x[pln[e]] = 1'b1;
        end
        default: begin
          x = x ^ set_mask;
          for (int e = 0; e < n; e++) if (spr[blk[e]]) x[pln[e]] = ~x[pln[e]];
        end
      endcase
      return x;
    endfunction

    function void note_pixel(kind_t k, logic [NPIX-1:0] spr, logic [NPIX-1:0] dst);
      pixel_result_t r;
      r.pix = blit(k, spr, dst);
      r.chg = 1'b0;
      for (int d = 0; d < (1 << NPIX); d++)
        if (blit(k, spr, NPIX'(d)) != NPIX'(d)) r.chg = 1'b1;
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [NPIX-1:0] pix, logic chg);
      pixel_result_t r;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pix=%h chg=%b", pix, chg));
      end else begin
        r = pending_q.pop_front();
        if (pix !== r.pix)
          report_mismatch($sformatf("new_pixel got %h want %h", pix, r.pix));
        if (chg !== r.chg)
          report_mismatch($sformatf("can_change got %b want %b", chg, r.chg));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         kind;
  logic [3:0]         sprite_bits;
  logic [3:0]         dest_pixel;
  logic               done;
  logic [3:0]         new_pixel;
  logic               can_change;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  pixel_op_scoreboard sb = new();
  int                 stall_cycles = 0;
  bit                 allow_gaps = 1'b1;

  planar_blitter_pixel_op u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .sprite_bits (sprite_bits),
    .dest_pixel  (dest_pixel),
    .done        (done),
    .new_pixel   (new_pixel),
    .can_change  (can_change),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both sides at the edge. Check the result before noting the input
  // accepted at the same edge: the pipeline never returns it that early.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) sb.check_result(new_pixel, can_change);
      if (start && !busy) sb.note_pixel(kind_t'(kind), sprite_bits, dest_pixel);
      if ((start && !busy) || done || (psel && penable && pready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Write one plane map over APB: setup cycle, then access cycle.
  task automatic write_map(input reg_idx_t r, input logic [MAP_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(r) * 4);
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.maps[r] = v;
  endtask

  task automatic load_maps(input logic [MAP_W-1:0] m0, input logic [MAP_W-1:0] m1,
                           input logic [MAP_W-1:0] m2, input logic [MAP_W-1:0] m3);
    write_map(REG_MAP0, m0);
    write_map(REG_MAP1, m1);
    write_map(REG_MAP2, m2);
    write_map(REG_MAP3, m3);
  endtask

  // Offer one transaction; idle at random first, scrambling the payload while
  // start is low so stale fields cannot pass for a real pixel.
  task automatic send_pixel(input kind_t k, input logic [3:0] spr, input logic [3:0] dst);
    while (allow_gaps && $urandom_range(99) < 12) begin
      start       <= 1'b0;
      kind        <= 2'($urandom_range(3));
      sprite_bits <= 4'($urandom_range(15));
      dest_pixel  <= 4'($urandom_range(15));
      @(posedge clk);
    end
    start       <= 1'b1;
    kind        <= k;
    sprite_bits <= spr;
    dest_pixel  <= dst;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(kind_t'($urandom_range(3)), 4'($urandom_range(15)),
                 4'($urandom_range(15)));
  endtask

  // Hold the sender until every pending result has come back, then let the
  // pipeline settle before touching the maps.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    logic [MAP_W-1:0] m [NMAPS];
    rst         <= 1'b1;
    start       <= 1'b0;
    kind        <= '0;
    sprite_bits <= '0;
    dest_pixel  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset maps leave the list empty and both masks clear: every op passes
    // the destination through untouched. Hit each op at the field extremes.
    for (int k = 0; k < 4; k++) begin
      send_pixel(kind_t'(k), 4'h0, 4'h0);
      send_pixel(kind_t'(k), 4'hF, 4'hF);
      send_pixel(kind_t'(k), 4'h5, 4'hA);
      send_pixel(kind_t'(k), 4'hA, 4'h5);
    end
    send_random(20);
    drain_results();

    // All maps full: block 0 alone fills the list, so later blocks add no entries;
    // clear and set masks are all ones; upper nibbles of maps 2 and 3 unused.
    load_maps(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(KIND_COPY, 4'h0, 4'hF);
    send_pixel(KIND_COPY, 4'hF, 4'h0);
    send_pixel(KIND_AND,  4'h0, 4'hF);
    send_pixel(KIND_OR,   4'hE, 4'h0);
    send_pixel(KIND_XOR,  4'hF, 4'hF);
    send_pixel(KIND_XOR,  4'h1, 4'h0);
    send_random(40);
    drain_results();

    // Straight one-to-one mapping; run this stretch back to back, no gaps.
    allow_gaps = 1'b0;
    load_maps(8'h01, 8'h02, 8'h04, 8'h08);
    send_random(80);
    drain_results();
    allow_gaps = 1'b1;

    // Empty first map: later maps must not feed the list; masks still act.
    load_maps(8'hA0, 8'h6F, 8'h0F, 8'hFF);
    send_random(40);
    drain_results();

    // Two blocks feed plane 0: earliest wins on copy, parity cancels on xor.
    load_maps(8'h11, 8'h91, 8'h26, 8'hF8);
    send_random(50);
    drain_results();

    // Empty map in the middle cuts the list short after block 0.
    load_maps(8'h02, 8'h40, 8'h0C, 8'h01);
    send_random(40);
    drain_results();

    // Random settings; sometimes zero a low nibble to end the list early.
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NMAPS; i++) begin
        m[i] = MAP_W'($urandom_range(255));
        if ($urandom_range(3) == 0) m[i][NIB_W-1:0] = '0;
      end
      load_maps(m[0], m[1], m[2], m[3]);
      send_random(40);
      drain_results();
    end

    // Drop back to the zero extreme to close out.
    load_maps(8'h00, 8'h00, 8'h00, 8'h00);
    send_random(20);
    drain_results();
    repeat (LATENCY + 2) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
